### sv/cal_pkg.sv
// ----------------------------------------------------------------------------
// cal_pkg
// Shared types, command codes and calendar helper functions for the
// Gregorian date counter.
// ----------------------------------------------------------------------------
package cal_pkg;

	// field widths
	localparam int YEAR_W = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W = 5;
	localparam int COUNT_W = 16;
	localparam int GAP_W = 22;
	localparam int SER_W = 23;

	// command codes
	localparam logic [2:0] CMD_LOAD = 3'd0;
	localparam logic [2:0] CMD_FWD = 3'd1;
	localparam logic [2:0] CMD_BWD = 3'd2;
	localparam logic [2:0] CMD_CMP = 3'd3;
	localparam logic [2:0] CMD_DIFF = 3'd4;

	// order codes
	localparam logic [1:0] ORD_EQUAL = 2'd0;
	localparam logic [1:0] ORD_LATER = 2'd1;
	localparam logic [1:0] ORD_EARLIER = 2'd2;

	// default date fields
	localparam logic [YEAR_W-1:0] RESET_YEAR = 14'd1970;
	localparam logic [MONTH_W-1:0] FIRST_MONTH = 4'd1;
	localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;
	localparam logic [DAY_W-1:0] FIRST_DAY = 5'd1;
	localparam logic [DAY_W-1:0] LAST_DAY = 5'd31;
	localparam logic [GAP_W-1:0] GAP_MAX = 22'h3FFFFF;

	// request word
	typedef struct packed {
		logic [2:0]         cmd;
		logic [YEAR_W-1:0]  year_in;
		logic [MONTH_W-1:0] month_in;
		logic [DAY_W-1:0]   day_in;
		logic [COUNT_W-1:0] step_count;
	} cal_req_t;

	// result word
	typedef struct packed {
		logic [YEAR_W-1:0]  year_out;
		logic [MONTH_W-1:0] month_out;
		logic [DAY_W-1:0]   day_out;
		logic [1:0]         order;
		logic [GAP_W-1:0]   day_gap;
		logic               fixed_flag;
	} cal_rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic validate;
		logic load;
		logic step;
		logic cmp;
		logic ser1;
		logic ser2;
		logic ser_other;
		logic gap;
	} cal_ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic [2:0] cmd;
		logic       step_end;
	} cal_sts_t;

	// leap test: y/100 by reciprocal multiply, then times 100 by shift-add
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [26:0] prod;
		logic [7:0] q;
		logic [YEAR_W-1:0] hund;
		prod = 27'(y) * 27'd5243;
		q = prod[26:19];
		hund = 14'({q, 6'b0}) + 14'({q, 5'b0}) + 14'({q, 2'b0});
		return (y[1:0] == 2'b00) && ((y != hund) || (q[1:0] == 2'b00));
	endfunction

	// days in month m
	function automatic logic [DAY_W-1:0] month_len(input logic leap,
			input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		case (m) inside
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// days before month m in a common year
	function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
		logic [8:0] d;
		case (m)
			4'd2: d = 9'd31;
			4'd3: d = 9'd59;
			4'd4: d = 9'd90;
			4'd5: d = 9'd120;
			4'd6: d = 9'd151;
			4'd7: d = 9'd181;
			4'd8: d = 9'd212;
			4'd9: d = 9'd243;
			4'd10: d = 9'd273;
			4'd11: d = 9'd304;
			4'd12: d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

### sv/calendar_date_counter_top.sv
// ----------------------------------------------------------------------------
// calendar_date_counter_top
// Gregorian date register with load, day stepping, compare and day
// difference commands, one result word per request word.
// ----------------------------------------------------------------------------
//  port     dir  width  handshake
//  request  in   42     taken at a rising edge with start high and busy low
//  result   out  48     valid for the single cycle that done is high
//
//  each command runs its own state sequence; step forward or backward runs
//  the stepper that moves one day per cycle until the count is used up or
//  a date limit is reached.
//  a new word can be taken in the cycle that done is high.
//  reset sets the stored date to 1970-01-01 and leaves the block idle.
//  the receiver cannot stall; the result word is shown once.
// ----------------------------------------------------------------------------
module calendar_date_counter_top import cal_pkg::*; #(
	parameter int MAX_YEAR = 9999
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  cal_req_t request,
	output logic     busy,
	output logic     done,
	output cal_rsp_t result
);

	cal_ctl_t ctl;
	cal_sts_t sts;

	// sequencer
	cal_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// date datapath
	cal_dp #(
		.MAX_YEAR (MAX_YEAR)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.ctl     (ctl),
		.sts     (sts),
		.result  (result)
	);

endmodule

### sv/cal_dp.sv
// ----------------------------------------------------------------------------
// cal_dp
// Date datapath: stored date, input validation, one-day stepper, day serial
// unit shared by both dates, and the compare / gap logic.
// ----------------------------------------------------------------------------
module cal_dp import cal_pkg::*; #(
	parameter int MAX_YEAR = 9999
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cal_req_t request,
	input  cal_ctl_t ctl,
	output cal_sts_t sts,
	output cal_rsp_t result
);

	localparam logic [YEAR_W-1:0] MaxYear = YEAR_W'(MAX_YEAR);

	cal_req_t req_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [YEAR_W-1:0] cur_year_q, o_year_q;
	logic [MONTH_W-1:0] cur_month_q, o_month_q;
	logic [DAY_W-1:0] cur_day_q, o_day_q;
	logic [1:0] order_q;
	logic [GAP_W-1:0] gap_q;
	logic flag_q;
	logic [SER_W-1:0] p365_q, sa_q, sb_q;
	logic [12:0] q4_q;
	logic [7:0] q100_q;
	logic [5:0] q400_q;
	logic [8:0] doy_q;

	// validation of the given date
	logic y_ok, m_ok, d_ok, v_fix;
	logic [YEAR_W-1:0] v_year;
	logic [MONTH_W-1:0] v_month;
	logic [DAY_W-1:0] v_len, v_day;

	always_comb begin
		y_ok = (req_q.year_in != '0) && (req_q.year_in <= MaxYear);
		v_year = y_ok ? req_q.year_in : RESET_YEAR;
		m_ok = (req_q.month_in != '0) && (req_q.month_in <= LAST_MONTH);
		v_month = m_ok ? req_q.month_in : FIRST_MONTH;
		v_len = month_len(is_leap(v_year), v_month);
		d_ok = (req_q.day_in != '0) && (req_q.day_in <= v_len);
		v_day = d_ok ? req_q.day_in : FIRST_DAY;
		v_fix = !(y_ok && m_ok && d_ok);
	end

	// one-day stepper
	logic cur_leap, fwd, at_max, at_min, at_lim;
	logic [DAY_W-1:0] cur_len, prev_len;
	logic [MONTH_W-1:0] prev_month;

	always_comb begin
		cur_leap = is_leap(cur_year_q);
		cur_len = month_len(cur_leap, cur_month_q);
		prev_month = cur_month_q - 4'd1;
		prev_len = month_len(cur_leap, prev_month);
		fwd = (req_q.cmd == CMD_FWD);
		at_max = (cur_year_q == MaxYear) && (cur_month_q == LAST_MONTH)
			&& (cur_day_q == LAST_DAY);
		at_min = (cur_year_q == 14'd1) && (cur_month_q == FIRST_MONTH)
			&& (cur_day_q == FIRST_DAY);
		at_lim = fwd ? at_max : at_min;
	end

	// serial stage one: products and quotients of the selected date
	logic [YEAR_W-1:0] s_year;
	logic [MONTH_W-1:0] s_month;
	logic [DAY_W-1:0] s_day;
	logic [14:0] a3, a99, a399;
	logic [26:0] pr100, pr400;
	logic [SER_W-1:0] p365, ser_sum, diff;
	logic [8:0] doy;

	always_comb begin
		s_year = ctl.ser_other ? o_year_q : cur_year_q;
		s_month = ctl.ser_other ? o_month_q : cur_month_q;
		s_day = ctl.ser_other ? o_day_q : cur_day_q;
		a3 = 15'(s_year) + 15'd3;
		a99 = 15'(s_year) + 15'd99;
		a399 = 15'(s_year) + 15'd399;
		pr100 = 27'(a99) * 27'd5243;
		pr400 = 27'(a399) * 27'd5243;
		p365 = SER_W'(s_year) * SER_W'(365);
		doy = cum_days(s_month) + 9'(s_day)
			+ 9'((is_leap(s_year) && (s_month > 4'd2)) ? 1 : 0);
		// serial stage two: sum of the registered terms
		ser_sum = p365_q + SER_W'(q4_q) - SER_W'(q100_q) + SER_W'(q400_q)
			+ SER_W'(doy_q);
		diff = (sa_q > sb_q) ? (sa_q - sb_q) : (sb_q - sa_q);
	end

	// stored date and command results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_year_q <= RESET_YEAR;
			cur_month_q <= FIRST_MONTH;
			cur_day_q <= FIRST_DAY;
			order_q <= ORD_EQUAL;
			gap_q <= '0;
			flag_q <= 1'b0;
		end else begin
			if (ctl.capture) begin
				order_q <= ORD_EQUAL;
				gap_q <= '0;
				flag_q <= 1'b0;
			end
			if (ctl.validate) begin
				flag_q <= v_fix;
				if (ctl.load) begin
					cur_year_q <= v_year;
					cur_month_q <= v_month;
					cur_day_q <= v_day;
				end
			end
			if (ctl.step && (cnt_q != '0)) begin
				if (at_lim) begin
					flag_q <= 1'b1;
				end else if (fwd) begin
					if (cur_day_q < cur_len) begin
						cur_day_q <= cur_day_q + 5'd1;
					end else begin
						cur_day_q <= FIRST_DAY;
						if (cur_month_q == LAST_MONTH) begin
							cur_month_q <= FIRST_MONTH;
							cur_year_q <= cur_year_q + 14'd1;
						end else begin
							cur_month_q <= cur_month_q + 4'd1;
						end
					end
				end else begin
					if (cur_day_q > FIRST_DAY) begin
						cur_day_q <= cur_day_q - 5'd1;
					end else if (cur_month_q == FIRST_MONTH) begin
						cur_month_q <= LAST_MONTH;
						cur_day_q <= LAST_DAY;
						cur_year_q <= cur_year_q - 14'd1;
					end else begin
						cur_month_q <= prev_month;
						cur_day_q <= prev_len;
					end
				end
			end
			if (ctl.cmp) begin
				if ({cur_year_q, cur_month_q, cur_day_q} > {o_year_q, o_month_q, o_day_q})
				begin
					order_q <= ORD_LATER;
				end else if ({cur_year_q, cur_month_q, cur_day_q}
						< {o_year_q, o_month_q, o_day_q}) begin
					order_q <= ORD_EARLIER;
				end else begin
					order_q <= ORD_EQUAL;
				end
			end
			if (ctl.gap) begin
				gap_q <= (diff > SER_W'(GAP_MAX)) ? GAP_MAX : diff[GAP_W-1:0];
			end
		end
	end

	// request word, step counter, validated date and serial terms
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			req_q <= request;
			cnt_q <= request.step_count;
		end
		if (ctl.validate) begin
			o_year_q <= v_year;
			o_month_q <= v_month;
			o_day_q <= v_day;
		end
		if (ctl.step && (cnt_q != '0) && !at_lim) begin
			cnt_q <= cnt_q - 16'd1;
		end
		if (ctl.ser1) begin
			p365_q <= p365;
			q4_q <= a3[14:2];
			q100_q <= pr100[26:19];
			q400_q <= pr400[26:21];
			doy_q <= doy;
		end
		if (ctl.ser2) begin
			if (ctl.ser_other) begin
				sb_q <= ser_sum;
			end else begin
				sa_q <= ser_sum;
			end
		end
	end

	assign sts.cmd = req_q.cmd;
	assign sts.step_end = (cnt_q == '0) || at_lim;

	assign result.year_out = cur_year_q;
	assign result.month_out = cur_month_q;
	assign result.day_out = cur_day_q;
	assign result.order = order_q;
	assign result.day_gap = gap_q;
	assign result.fixed_flag = flag_q;

`ifndef ASSERT_OFF
	// stored date is always a real date within range
	a_date_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_year_q != '0) && (cur_year_q <= MaxYear) && (cur_month_q != '0)
		&& (cur_month_q <= LAST_MONTH) && (cur_day_q != '0)
		&& (cur_day_q <= month_len(is_leap(cur_year_q), cur_month_q)))
		else $error("stored date out of range");

	// each stepping cycle that moves the date uses up one day of the count
	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step && !sts.step_end |=> cnt_q == $past(cnt_q) - 16'd1)
		else $error("step counter did not advance");

	// order code is never the unused value
	a_order_code: assert property (@(posedge clk) disable iff (!arst_n)
		order_q != 2'd3)
		else $error("bad order code");
`endif

endmodule

### sv/cal_ctrl.sv
// ----------------------------------------------------------------------------
// cal_ctrl
// Command sequencer: takes a request word, dispatches on its command and
// walks the datapath through validation, stepping, compare or the serial passes.
// ----------------------------------------------------------------------------
module cal_ctrl import cal_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  cal_sts_t sts,
	output cal_ctl_t ctl,
	output logic     busy,
	output logic     done
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_VAL,
		S_STEP,
		S_CMP,
		S_SA1,
		S_SA2,
		S_SB1,
		S_SB2,
		S_GAP
	} state_t;

	state_t state_q;
	logic busy_q, done_q;

	// state, busy and done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q) inside
				S_IDLE: begin
					if (start) begin
						state_q <= S_DISP;
						busy_q <= 1'b1;
					end
				end
				S_DISP: begin
					unique case (sts.cmd) inside
						CMD_LOAD, CMD_CMP, CMD_DIFF: state_q <= S_VAL;
						CMD_FWD, CMD_BWD: state_q <= S_STEP;
						default: begin
							state_q <= S_IDLE;
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					endcase
				end
				S_VAL: begin
					unique case (sts.cmd) inside
						CMD_CMP: state_q <= S_CMP;
						CMD_DIFF: state_q <= S_SA1;
						default: begin
							state_q <= S_IDLE;
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					endcase
				end
				S_STEP: begin
					if (sts.step_end) begin
						state_q <= S_IDLE;
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
				S_SA1: state_q <= S_SA2;
				S_SA2: state_q <= S_SB1;
				S_SB1: state_q <= S_SB2;
				S_SB2: state_q <= S_GAP;
				S_CMP, S_GAP: begin
					state_q <= S_IDLE;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	// datapath commands decoded from state
	always_comb begin
		ctl = '0;
		ctl.capture = (state_q == S_IDLE) && start;
		ctl.validate = (state_q == S_VAL);
		ctl.load = (state_q == S_VAL) && (sts.cmd == CMD_LOAD);
		ctl.step = (state_q == S_STEP);
		ctl.cmp = (state_q == S_CMP);
		ctl.ser1 = (state_q == S_SA1) || (state_q == S_SB1);
		ctl.ser2 = (state_q == S_SA2) || (state_q == S_SB2);
		ctl.ser_other = (state_q == S_SB1) || (state_q == S_SB2);
		ctl.gap = (state_q == S_GAP);
	end

	assign busy = busy_q;
	assign done = done_q;

`ifndef ASSERT_OFF
	// a word is never reported while the block is still working
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("done while busy");

	// an accepted word always starts work on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy_q |=> busy_q)
		else $error("accepted word not started");

	// busy tracks the state register
	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != S_IDLE))
		else $error("busy out of step with state");
`endif

endmodule
